FILE: rtl/core/bcwm_pkg.sv
// ----------------------------------------------------------------------------
// bcwm_pkg
// shared types and constants of the bunch-crossing window mask matcher
// ----------------------------------------------------------------------------
package bcwm_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
    localparam int CNT_ENTRY_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int MASK_BITS     = 128;
    localparam int MASK_AW       = $clog2(MASK_BITS);
    localparam int CNT_W         = 32;
    localparam int BC_W          = 63;
    localparam int TOL_W         = 12;
    localparam int WORD_W        = 64;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_QSETUP,
        S_QRD,
        S_QEVAL,
        S_CRD,
        S_CWR,
        S_RDCNT,
        S_RDWAIT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [BC_W-1:0]      start_bc;
        logic [BC_W-1:0]      stop_bc;
        logic [MASK_BITS-1:0] mask;
        logic                 accounted;
    } tbl_entry_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [TBL_AW-1:0] addr;
        tbl_entry_t        wdata;
    } tbl_req_t;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic               clear;
        logic [MASK_AW-1:0] addr;
        logic [CNT_W-1:0]   wdata;
    } cnt_req_t;

endpackage

FILE: rtl/core/bcwm_ifs.sv
// ----------------------------------------------------------------------------
// bcwm channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface bcwm_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  op;
    logic [bcwm_pkg::BC_W-1:0]   bc_id;
    logic [bcwm_pkg::BC_W-1:0]   range_start;
    logic [bcwm_pkg::BC_W-1:0]   range_end;
    logic [bcwm_pkg::WORD_W-1:0] mask_low;
    logic [bcwm_pkg::WORD_W-1:0] mask_high;
    logic [6:0]                  counter_index;

    modport source (output valid, op, bc_id, range_start, range_end, mask_low, mask_high,
                    counter_index, input ready);
    modport sink (input valid, op, bc_id, range_start, range_end, mask_low, mask_high,
                  counter_index, output ready);
endinterface

interface bcwm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bcwm_pkg::WORD_W-1:0] sel_mask_low;
    logic [bcwm_pkg::WORD_W-1:0] sel_mask_high;
    logic                        none_selected;
    logic [bcwm_pkg::CNT_W-1:0]  counter_value;
    logic                        table_full;

    modport source (output valid, sel_mask_low, sel_mask_high, none_selected, counter_value,
                    table_full, input ready);
    modport sink (input valid, sel_mask_low, sel_mask_high, none_selected, counter_value,
                  table_full, output ready);
endinterface

FILE: rtl/core/bcwm_table.sv
// ----------------------------------------------------------------------------
// bcwm_table
// range table memory: bounds, mask and accounted flag per entry
// ----------------------------------------------------------------------------
module bcwm_table (
    input  logic                clk,
    input  bcwm_pkg::tbl_req_t  req,
    output bcwm_pkg::tbl_entry_t rd_data
);
    import bcwm_pkg::*;

    tbl_entry_t mem [TABLE_ENTRIES];
    tbl_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: rtl/core/bcwm_counters.sv
// ----------------------------------------------------------------------------
// bcwm_counters
// trigger bit counter memory with per-entry valid bits for reset and clear
// ----------------------------------------------------------------------------
module bcwm_counters (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bcwm_pkg::cnt_req_t           req,
    output logic [bcwm_pkg::CNT_W-1:0]   rd_data
);
    import bcwm_pkg::*;

    logic [CNT_W-1:0]     mem [MASK_BITS];
    logic [CNT_W-1:0]     rd_data_reg;
    logic                 rd_valid_reg;
    logic [MASK_BITS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    // an entry never written since clear reads as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;
endmodule

FILE: rtl/core/bc_window_trigger_mask_matcher_unit.sv
// ----------------------------------------------------------------------------
// bc_window_trigger_mask_matcher_unit
// bunch-crossing window matcher over a loaded range table with mask counters
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Load goes through S_LOAD, clear straight
// to S_FIN, counter read through S_RDCNT and S_RDWAIT. A query scans the table
// entries from the cursor until the table ends or a range past the window ends the
// scan; for each overlapping range seen for the first time, a counter sweep visits
// every mask bit, since the counters sit in a single-port memory updated one bit
// per read-modify-write. Results are held in an output register; a new transaction
// is taken once the previous result is registered.
module bc_window_trigger_mask_matcher_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    bcwm_req_if.sink                    req,
    bcwm_rsp_if.source                  rsp,
    input  logic                        cfg_we,
    input  logic [bcwm_pkg::TOL_W-1:0]  cfg_wdata
);
    import bcwm_pkg::*;

    state_t state_reg, state_next;

    logic [TOL_W-1:0]       tol_reg;
    op_t                    op_reg;
    logic [BC_W-1:0]        bc_reg;
    logic [BC_W-1:0]        rs_reg;
    logic [BC_W-1:0]        re_reg;
    logic [MASK_BITS-1:0]   mask_reg;
    logic [MASK_AW-1:0]     cidx_reg;

    logic [CNT_ENTRY_W-1:0] count_reg, count_next;
    logic [TBL_AW-1:0]      cursor_reg, cursor_next;
    logic [BC_W-1:0]        prev_reg, prev_next;
    logic [CNT_ENTRY_W-1:0] idx_reg, idx_next;
    logic [BC_W-1:0]        lo_reg, lo_next;
    logic [BC_W:0]          hi_reg, hi_next;
    logic                   passed_reg, passed_next;
    logic                   overlapped_reg, overlapped_next;
    logic [MASK_BITS-1:0]   sel_reg, sel_next;
    logic [MASK_BITS-1:0]   acc_mask_reg, acc_mask_next;
    logic [MASK_AW-1:0]     bit_reg, bit_next;
    logic [CNT_W-1:0]       cval_reg, cval_next;
    logic                   full_reg, full_next;

    logic                   out_valid_reg;
    logic [MASK_BITS-1:0]   out_sel_reg;
    logic                   out_none_reg;
    logic [CNT_W-1:0]       out_cval_reg;
    logic                   out_full_reg;
    logic                   out_load;

    tbl_req_t               tbl_req;
    tbl_entry_t             tbl_rd;
    cnt_req_t               cnt_req;
    logic [CNT_W-1:0]       cnt_rd;

    logic                   accept;
    logic                   ovl;
    logic                   before_win;
    logic                   last_bit;

    bcwm_table u_table (
        .clk     (clk),
        .req     (tbl_req),
        .rd_data (tbl_rd)
    );

    bcwm_counters u_counters (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (cnt_req),
        .rd_data (cnt_rd)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign before_win = tbl_rd.stop_bc < lo_reg;
    assign ovl        = !before_win && !({1'b0, tbl_rd.start_bc} > hi_reg);
    assign last_bit   = (bit_reg == MASK_AW'(MASK_BITS - 1));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        prev_next       = prev_reg;
        idx_next        = idx_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        passed_next     = passed_reg;
        overlapped_next = overlapped_reg;
        sel_next        = sel_reg;
        acc_mask_next   = acc_mask_reg;
        bit_next        = bit_reg;
        cval_next       = cval_reg;
        full_next       = full_reg;
        out_load        = 1'b0;
        tbl_req         = '0;
        cnt_req         = '0;
        tbl_req.addr    = idx_reg[TBL_AW-1:0];
        cnt_req.addr    = bit_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sel_next  = '0;
                    cval_next = '0;
                    full_next = 1'b0;
                    unique case (op_t'(req.op))
                        OP_LOAD:  state_next = S_LOAD;
                        OP_QUERY: state_next = S_QSETUP;
                        OP_CLEAR:
                        begin
                            count_next    = '0;
                            cursor_next   = '0;
                            prev_next     = '0;
                            cnt_req.clear = 1'b1;
                            state_next    = S_FIN;
                        end
                        OP_READ:  state_next = S_RDCNT;
                        default:  state_next = S_FIN;
                    endcase
                end
            end
            S_LOAD:
            begin
                if (count_reg == CNT_ENTRY_W'(TABLE_ENTRIES))
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    tbl_req.wr_en           = 1'b1;
                    tbl_req.addr            = count_reg[TBL_AW-1:0];
                    tbl_req.wdata.start_bc  = (rs_reg < re_reg) ? rs_reg : re_reg;
                    tbl_req.wdata.stop_bc   = (rs_reg < re_reg) ? re_reg : rs_reg;
                    tbl_req.wdata.mask      = mask_reg;
                    tbl_req.wdata.accounted = 1'b0;
                    count_next              = count_reg + 1'b1;
                end
                state_next = S_FIN;
            end
            S_QSETUP:
            begin
                lo_next         = (bc_reg > BC_W'(tol_reg)) ? bc_reg - BC_W'(tol_reg) : '0;
                hi_next         = {1'b0, bc_reg} + (BC_W + 1)'(tol_reg);
                passed_next     = 1'b0;
                overlapped_next = 1'b0;
                prev_next       = bc_reg;
                // ids going backwards restart the scan from the top
                if (bc_reg < prev_reg)
                begin
                    cursor_next = '0;
                    idx_next    = '0;
                end
                else
                begin
                    idx_next = CNT_ENTRY_W'(cursor_reg);
                end
                state_next = S_QRD;
            end
            S_QRD:
            begin
                if (idx_reg < count_reg)
                begin
                    tbl_req.rd_en = 1'b1;
                    state_next    = S_QEVAL;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_QEVAL:
            begin
                if (ovl)
                begin
                    sel_next        = sel_reg | tbl_rd.mask;
                    overlapped_next = 1'b1;
                    if (!overlapped_reg && !passed_reg)
                    begin
                        cursor_next = idx_reg[TBL_AW-1:0];
                    end
                    if (!tbl_rd.accounted)
                    begin
                        tbl_req.wr_en           = 1'b1;
                        tbl_req.wdata           = tbl_rd;
                        tbl_req.wdata.accounted = 1'b1;
                        acc_mask_next           = tbl_rd.mask;
                        bit_next                = '0;
                        state_next              = S_CRD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_QRD;
                    end
                end
                else if (before_win)
                begin
                    cursor_next = idx_reg[TBL_AW-1:0];
                    passed_next = 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    state_next  = S_QRD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_CRD:
            begin
                if (acc_mask_reg[bit_reg])
                begin
                    cnt_req.rd_en = 1'b1;
                    state_next    = S_CWR;
                end
                else if (last_bit)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_QRD;
                end
                else
                begin
                    bit_next = bit_reg + 1'b1;
                end
            end
            S_CWR:
            begin
                cnt_req.wr_en = 1'b1;
                // saturating increment
                cnt_req.wdata = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
                if (last_bit)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_QRD;
                end
                else
                begin
                    bit_next   = bit_reg + 1'b1;
                    state_next = S_CRD;
                end
            end
            S_RDCNT:
            begin
                cnt_req.rd_en = 1'b1;
                cnt_req.addr  = cidx_reg;
                state_next    = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                cval_next  = cnt_rd;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tol_reg       <= '0;
            count_reg     <= '0;
            cursor_reg    <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            prev_reg   <= prev_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(req.op);
            bc_reg   <= req.bc_id;
            rs_reg   <= req.range_start;
            re_reg   <= req.range_end;
            mask_reg <= {req.mask_high, req.mask_low};
            cidx_reg <= req.counter_index;
        end
        idx_reg        <= idx_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        passed_reg     <= passed_next;
        overlapped_reg <= overlapped_next;
        sel_reg        <= sel_next;
        acc_mask_reg   <= acc_mask_next;
        bit_reg        <= bit_next;
        cval_reg       <= cval_next;
        full_reg       <= full_next;
        if (out_load)
        begin
            out_sel_reg  <= sel_reg;
            out_none_reg <= (op_reg == OP_QUERY) && (sel_reg == '0);
            out_cval_reg <= cval_reg;
            out_full_reg <= full_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.sel_mask_low  = out_sel_reg[WORD_W-1:0];
    assign rsp.sel_mask_high = out_sel_reg[MASK_BITS-1:WORD_W];
    assign rsp.none_selected = out_none_reg;
    assign rsp.counter_value = out_cval_reg;
    assign rsp.table_full    = out_full_reg;
endmodule
